// ===== rtl/gmcp_pkg.sv =====
// Shared types and constants for the grid minimum-cost path block.
// Used by gmcp_ctrl, gmcp_dp and grid_min_cost_path; depends on nothing.
`default_nettype none

package gmcp_pkg;

	// Field widths fixed by the stream payload
	localparam int IDX_W  = 6;
	localparam int WT_W   = 4;
	localparam int COST_W = 10;
	// Row/column coordinate width, covers grids up to 8 x 8
	localparam int CRD_W  = 3;

	localparam logic [COST_W-1:0] COST_MAX = 10'd1023;

	// Request kinds carried on tuser
	localparam logic REQ_LOAD    = 1'b0;
	localparam logic REQ_COMPUTE = 1'b1;

	// Per-cell sequencer phases
	localparam logic [2:0] PH_LEFT  = 3'd0; // column - 1
	localparam logic [2:0] PH_RIGHT = 3'd1; // column + 1
	localparam logic [2:0] PH_UP    = 3'd2; // row - 1
	localparam logic [2:0] PH_DOWN  = 3'd3; // row + 1
	localparam logic [2:0] PH_SELF  = 3'd4; // own cost and weight
	localparam logic [2:0] PH_RELAX = 3'd5; // compare and write back

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_INIT  = 5'b00010,
		ST_SWEEP = 5'b00100,
		ST_FINAL = 5'b01000,
		ST_EMIT  = 5'b10000
	} gmcp_state_t;

	// Request payload, last field in the lowest bits
	typedef struct packed {
		logic [IDX_W-1:0] end_cell;
		logic [IDX_W-1:0] start_cell;
		logic [WT_W-1:0]  cell_weight;
		logic [IDX_W-1:0] cell_index;
	} gmcp_req_t;

	// Controller to datapath commands
	typedef struct packed {
		logic             ld_wr;    // store one weight
		logic             latch;    // capture compute request
		logic             init_wr;  // write initial cost of cell
		logic             rd_en;    // issue cost read for current phase
		logic             use_end;  // address around the end cell
		logic             min_clr;  // restart neighbor minimum
		logic             relax;    // compare candidate and write back
		logic             chg_clr;  // clear pass change flag
		logic             emit;     // load result register
		logic [2:0]       phase;
		logic [IDX_W-1:0] cur_cell;
		logic [CRD_W-1:0] row;
		logic [CRD_W-1:0] col;
	} gmcp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic changed;   // some cost dropped in this pass
		logic out_free;  // result register can take a value
	} gmcp_status_t;

endpackage

`default_nettype wire

// ===== rtl/grid_min_cost_path.sv =====
// Grid minimum-cost path: a load transaction stores one cell weight. A compute transaction
// writes the initial cost of all GRID_COLS*GRID_ROWS cells, then runs P relaxation passes that
// visit each cell in turn (one cost-memory read port: four neighbors, own cost, write back),
// then gathers the end cell's neighbors and loads the result; P >= 1 depends on the data.
// One transaction at a time; a finished result waits in an output register.
// Reset clears control only; weights are undefined until loaded.
`default_nettype none

module grid_min_cost_path #(
	parameter int GRID_COLS = 7,
	parameter int GRID_ROWS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// [5:0] cell_index, [9:6] cell_weight, [15:10] start_cell, [21:16] end_cell
	input  wire logic [23:0] s_axis_tdata,
	// [0] req_type
	input  wire logic        s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [9:0] best_cost, [10] saturated
	output logic [15:0]      m_axis_tdata
);

	gmcp_pkg::gmcp_cmd_t    cmd;
	gmcp_pkg::gmcp_status_t status;
	gmcp_pkg::gmcp_req_t    req;
	logic [gmcp_pkg::COST_W-1:0] best_cost;
	logic                        saturated;

	assign req = s_axis_tdata[$bits(gmcp_pkg::gmcp_req_t)-1:0];

	gmcp_ctrl #(
		.GRID_COLS (GRID_COLS),
		.GRID_ROWS (GRID_ROWS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_valid    (s_axis_tvalid),
		.s_req_type (s_axis_tuser),
		.s_ready    (s_axis_tready),
		.status     (status),
		.cmd        (cmd)
	);

	gmcp_dp #(
		.GRID_COLS (GRID_COLS),
		.GRID_ROWS (GRID_ROWS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.req     (req),
		.status  (status),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.m_cost  (best_cost),
		.m_sat   (saturated)
	);

	assign m_axis_tdata = {5'b0, saturated, best_cost};

	// Saturated flag agrees with the cost it marks
	a_sat_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[10] == (m_axis_tdata[9:0] == gmcp_pkg::COST_MAX)))
		else $error("saturated flag disagrees with best_cost");

	// A result is loaded only into a free output register
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> status.out_free)
		else $error("result loaded over an untaken result");

	// No sweep activity while new transactions are taken
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> (!cmd.rd_en && !cmd.relax && !cmd.init_wr))
		else $error("cost memory active while accepting input");

	// Cost memory has one write source at a time
	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.init_wr, cmd.relax, cmd.ld_wr}))
		else $error("conflicting memory write commands");

endmodule

`default_nettype wire

// ===== rtl/gmcp_ctrl.sv =====
// Sequencer for the grid minimum-cost path block: weight loads, init sweep, relaxation passes, result.
// Depends on gmcp_pkg; drives gmcp_dp through gmcp_cmd_t.
`default_nettype none

module gmcp_ctrl #(
	parameter int GRID_COLS = 7,
	parameter int GRID_ROWS = 8
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    s_valid,
	input  wire logic                    s_req_type,
	output logic                         s_ready,
	input  wire gmcp_pkg::gmcp_status_t  status,
	output gmcp_pkg::gmcp_cmd_t          cmd
);

	localparam int CW = gmcp_pkg::CRD_W;
	localparam int IW = gmcp_pkg::IDX_W;
	localparam logic [CW-1:0] ROW_LAST = CW'(GRID_ROWS - 1);
	localparam logic [CW-1:0] COL_LAST = CW'(GRID_COLS - 1);

	gmcp_pkg::gmcp_state_t state_q;
	logic [IW-1:0] cell_q;
	logic [CW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic [2:0]    phase_q;
	logic          last_cell;
	logic          accept;

	assign last_cell = (row_q == ROW_LAST) && (col_q == COL_LAST);
	assign s_ready   = (state_q == gmcp_pkg::ST_IDLE);
	assign accept    = s_ready && s_valid;

	// Command decode
	always_comb begin
		cmd          = '0;
		cmd.phase    = phase_q;
		cmd.cur_cell = cell_q;
		cmd.row      = row_q;
		cmd.col      = col_q;
		unique case (state_q)
			gmcp_pkg::ST_IDLE: begin
				cmd.ld_wr = accept && (s_req_type == gmcp_pkg::REQ_LOAD);
				cmd.latch = accept && (s_req_type == gmcp_pkg::REQ_COMPUTE);
			end
			gmcp_pkg::ST_INIT: begin
				cmd.init_wr = 1'b1;
				cmd.chg_clr = last_cell;
			end
			gmcp_pkg::ST_SWEEP: begin
				cmd.rd_en   = (phase_q != gmcp_pkg::PH_RELAX);
				cmd.min_clr = (phase_q == gmcp_pkg::PH_LEFT);
				cmd.relax   = (phase_q == gmcp_pkg::PH_RELAX);
				cmd.chg_clr = cmd.relax && last_cell && status.changed;
			end
			gmcp_pkg::ST_FINAL: begin
				cmd.use_end = 1'b1;
				cmd.rd_en   = (phase_q != gmcp_pkg::PH_SELF);
				cmd.min_clr = (phase_q == gmcp_pkg::PH_LEFT);
			end
			gmcp_pkg::ST_EMIT: begin
				cmd.emit = status.out_free;
			end
			default: begin
				cmd.phase = phase_q;
			end
		endcase
	end

	// State, cell walk and phase counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gmcp_pkg::ST_IDLE;
			cell_q  <= '0;
			row_q   <= '0;
			col_q   <= '0;
			phase_q <= gmcp_pkg::PH_LEFT;
		end else begin
			unique case (state_q)
				gmcp_pkg::ST_IDLE: begin
					cell_q  <= '0;
					row_q   <= '0;
					col_q   <= '0;
					phase_q <= gmcp_pkg::PH_LEFT;
					if (cmd.latch) begin
						state_q <= gmcp_pkg::ST_INIT;
					end
				end
				gmcp_pkg::ST_INIT: begin
					if (last_cell) begin
						cell_q  <= '0;
						row_q   <= '0;
						col_q   <= '0;
						state_q <= gmcp_pkg::ST_SWEEP;
					end else begin
						cell_q <= cell_q + 1'b1;
						if (row_q == ROW_LAST) begin
							row_q <= '0;
							col_q <= col_q + 1'b1;
						end else begin
							row_q <= row_q + 1'b1;
						end
					end
				end
				gmcp_pkg::ST_SWEEP: begin
					if (phase_q == gmcp_pkg::PH_RELAX) begin
						phase_q <= gmcp_pkg::PH_LEFT;
						if (last_cell) begin
							cell_q <= '0;
							row_q  <= '0;
							col_q  <= '0;
							if (!status.changed) begin
								state_q <= gmcp_pkg::ST_FINAL;
							end
						end else begin
							cell_q <= cell_q + 1'b1;
							if (row_q == ROW_LAST) begin
								row_q <= '0;
								col_q <= col_q + 1'b1;
							end else begin
								row_q <= row_q + 1'b1;
							end
						end
					end else begin
						phase_q <= phase_q + 1'b1;
					end
				end
				gmcp_pkg::ST_FINAL: begin
					if (phase_q == gmcp_pkg::PH_SELF) begin
						phase_q <= gmcp_pkg::PH_LEFT;
						state_q <= gmcp_pkg::ST_EMIT;
					end else begin
						phase_q <= phase_q + 1'b1;
					end
				end
				gmcp_pkg::ST_EMIT: begin
					if (status.out_free) begin
						state_q <= gmcp_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= gmcp_pkg::ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/gmcp_dp.sv =====
// Datapath for the grid minimum-cost path block: weight and cost memories,
// neighbor addressing, running minimum, saturating add and result register.
// Depends on gmcp_pkg; commanded by gmcp_ctrl.
`default_nettype none

module gmcp_dp #(
	parameter int GRID_COLS = 7,
	parameter int GRID_ROWS = 8
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire gmcp_pkg::gmcp_cmd_t    cmd,
	input  wire gmcp_pkg::gmcp_req_t    req,
	output gmcp_pkg::gmcp_status_t      status,
	output logic                        m_valid,
	input  wire logic                   m_ready,
	output logic [gmcp_pkg::COST_W-1:0] m_cost,
	output logic                        m_sat
);

	localparam int CELL_COUNT = GRID_COLS * GRID_ROWS;
	localparam int AW = $clog2(CELL_COUNT);
	localparam int IW = gmcp_pkg::IDX_W;
	localparam int CW = gmcp_pkg::CRD_W;
	localparam int KW = gmcp_pkg::COST_W;
	localparam int WW = gmcp_pkg::WT_W;
	localparam logic [IW-1:0] ROWS_I   = IW'(GRID_ROWS);
	localparam logic [IW:0]   CELLS_I  = (IW + 1)'(CELL_COUNT);
	localparam logic [CW-1:0] ROW_LAST = CW'(GRID_ROWS - 1);
	localparam logic [CW-1:0] COL_LAST = CW'(GRID_COLS - 1);

	logic [WW-1:0] weight_mem [CELL_COUNT];
	logic [KW-1:0] cost_mem   [CELL_COUNT];

	logic [IW-1:0] start_q;
	logic [IW-1:0] end_q;
	logic [CW-1:0] end_row_q;
	logic [CW-1:0] end_col_q;
	logic          end_hit_q;
	logic [KW-1:0] cost_rd_q;
	logic [WW-1:0] wt_rd_q;
	logic [KW-1:0] min_q;
	logic          nb_s1;
	logic          chg_q;
	logic          out_valid_q;
	logic [KW-1:0] out_cost_q;

	logic [IW-1:0] base;
	logic [CW-1:0] brow;
	logic [CW-1:0] bcol;
	logic [IW-1:0] rd_addr;
	logic          rd_ok;
	logic          rd_go;
	logic          ld_ok;
	logic [KW:0]   sum;
	logic [KW-1:0] cand;
	logic          upd;
	logic          cost_we;
	logic [KW-1:0] cost_wd;

	// Neighbor address and in-grid check for the current phase
	always_comb begin
		base = cmd.use_end ? end_q : cmd.cur_cell;
		brow = cmd.use_end ? end_row_q : cmd.row;
		bcol = cmd.use_end ? end_col_q : cmd.col;
		case (cmd.phase)
			gmcp_pkg::PH_LEFT: begin
				rd_addr = base - ROWS_I;
				rd_ok   = (bcol != '0);
			end
			gmcp_pkg::PH_RIGHT: begin
				rd_addr = base + ROWS_I;
				rd_ok   = (bcol != COL_LAST);
			end
			gmcp_pkg::PH_UP: begin
				rd_addr = base - 1'b1;
				rd_ok   = (brow != '0);
			end
			gmcp_pkg::PH_DOWN: begin
				rd_addr = base + 1'b1;
				rd_ok   = (brow != ROW_LAST);
			end
			gmcp_pkg::PH_SELF: begin
				rd_addr = base;
				rd_ok   = 1'b1;
			end
			default: begin
				rd_addr = base;
				rd_ok   = 1'b0;
			end
		endcase
		if (cmd.use_end) begin
			rd_ok = rd_ok && end_hit_q;
		end
	end

	assign rd_go = cmd.rd_en && rd_ok;
	assign ld_ok = cmd.ld_wr && ({1'b0, req.cell_index} < CELLS_I);

	// Candidate: neighbor minimum plus own weight, saturated
	assign sum  = {1'b0, min_q} + {{(KW + 1 - WW){1'b0}}, wt_rd_q};
	assign cand = (sum > {1'b0, gmcp_pkg::COST_MAX}) ? gmcp_pkg::COST_MAX : sum[KW-1:0];
	assign upd  = cmd.relax && (cand < cost_rd_q);

	assign cost_we = cmd.init_wr || upd;
	assign cost_wd = cmd.init_wr ? ((cmd.cur_cell == start_q) ? '0 : gmcp_pkg::COST_MAX)
		: cand;

	// Weight memory
	always_ff @(posedge clk) begin
		if (ld_ok) begin
			weight_mem[req.cell_index[AW-1:0]] <= req.cell_weight;
		end
		if (cmd.rd_en && (cmd.phase == gmcp_pkg::PH_SELF)) begin
			wt_rd_q <= weight_mem[cmd.cur_cell[AW-1:0]];
		end
	end

	// Cost memory
	always_ff @(posedge clk) begin
		if (cost_we) begin
			cost_mem[cmd.cur_cell[AW-1:0]] <= cost_wd;
		end
		if (rd_go) begin
			cost_rd_q <= cost_mem[rd_addr[AW-1:0]];
		end
	end

	// Request capture, end cell coordinates, running minimum and result cost
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			start_q <= req.start_cell;
			end_q   <= req.end_cell;
		end
		if (cmd.init_wr && (cmd.cur_cell == end_q)) begin
			end_row_q <= cmd.row;
			end_col_q <= cmd.col;
		end
		if (cmd.min_clr) begin
			min_q <= gmcp_pkg::COST_MAX;
		end else if (nb_s1 && (cost_rd_q < min_q)) begin
			min_q <= cost_rd_q;
		end
		if (cmd.emit) begin
			out_cost_q <= min_q;
		end
	end

	// Control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_hit_q   <= 1'b0;
			nb_s1       <= 1'b0;
			chg_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.latch) begin
				end_hit_q <= 1'b0;
			end else if (cmd.init_wr && (cmd.cur_cell == end_q)) begin
				end_hit_q <= 1'b1;
			end
			nb_s1 <= rd_go && (cmd.phase != gmcp_pkg::PH_SELF);
			if (cmd.chg_clr) begin
				chg_q <= 1'b0;
			end else if (upd) begin
				chg_q <= 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.changed  = chg_q || upd;
	assign status.out_free = !out_valid_q || m_ready;

	assign m_valid = out_valid_q;
	assign m_cost  = out_cost_q;
	assign m_sat   = (out_cost_q == gmcp_pkg::COST_MAX);

endmodule

`default_nettype wire
